FILE: rtl/core/ntbc_pkg.sv
// Shared types, constants and the corner hash of the terrain block classifier.
// No dependencies; imported by the interfaces and the top level.
`default_nettype none

package ntbc_pkg;

  localparam int unsigned HeightDef = 128;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned PosYW    = 7;
  localparam int unsigned KindW    = 3;
  localparam int unsigned ColHW    = 7;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned WaterW   = 7;

  localparam int unsigned NumStg = 8;

  typedef enum logic [KindW-1:0] {
    KindAir     = 3'd0,
    KindBedrock = 3'd1,
    KindDirt    = 3'd2,
    KindStone   = 3'd3,
    KindGrass   = 3'd4,
    KindWater   = 3'd5
  } block_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNoiseSeed  = 1'b0,
    CfgWaterLevel = 1'b1
  } cfg_idx_e;

  // Q0.16 sample scales of the two octaves
  localparam logic [12:0] OctScale [2] = '{13'd3277, 13'd655};

  // only the low byte of each hash multiplier reaches the corner value
  localparam logic [7:0] HashMulXLo = 8'(73856093);
  localparam logic [7:0] HashMulYLo = 8'(19349663);

  localparam logic [WaterW-1:0] WaterLevelRst = 7'd64;
  localparam logic [7:0]        HeightBase    = 8'd64;
  localparam logic [17:0]       SmoothThree   = 18'h30000;
  localparam logic [14:0]       ValueSpan     = 15'd255;
  localparam logic [8:0]        BedrockTop    = 9'd4;
  localparam logic [8:0]        DirtDepth     = 9'd3;

  function automatic logic [7:0] corner_hash(input logic [7:0] cx, input logic [7:0] cy);
    logic [15:0] hx;
    logic [15:0] hy;
    hx = cx * HashMulXLo;
    hy = cy * HashMulYLo;
    return hx[7:0] ^ hy[7:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ntbc_if.sv
// Valid/ready channels of the terrain block classifier: voxel request and result.
// Depends on ntbc_pkg for field widths.
`default_nettype none

interface ntbc_req_if;
  logic                                valid;
  logic                                ready;
  logic signed [ntbc_pkg::CoordW-1:0] pos_x;
  logic        [ntbc_pkg::PosYW-1:0]  pos_y;
  logic signed [ntbc_pkg::CoordW-1:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface ntbc_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ntbc_pkg::KindW-1:0]  block_kind;
  logic [ntbc_pkg::ColHW-1:0]  column_height;

  modport source (output valid, output block_kind, output column_height, input ready);
  modport sink   (input valid, input block_kind, input column_height, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/noise_terrain_block_classifier.sv
// Terrain voxel classifier: two octaves of hashed value noise give the column height,
// then the voxel height picks the block kind. Depends on ntbc_pkg and ntbc_if.
//
//   channel   dir   handshake        payload
//   req       in    valid/ready      pos_x, pos_y, pos_z
//   rsp       out   valid/ready      block_kind, column_height
//   cfg       in    cfg_we_i         cfg_idx_i, cfg_data_i
//
// Eight register stages, the last one the output register; one request per cycle
// while rsp is ready. Each stage holds at most one multiplier level.
// Each stage advances when it is empty or the next stage advances, so bubbles
// close up under a stall and nothing is lost or repeated.
// Reset clears the valid bits and loads seed 0 and water level 64.
`default_nettype none

module noise_terrain_block_classifier #(
  parameter int unsigned HEIGHT = ntbc_pkg::HeightDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ntbc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ntbc_pkg::CfgDataW-1:0]   cfg_data_i,
  ntbc_req_if.sink                        req,
  ntbc_rsp_if.source                      rsp
);
  import ntbc_pkg::*;

  localparam logic [7:0] HMax   = 8'(HEIGHT - 1);
  localparam logic [8:0] HLimit = 9'(HEIGHT);

  // configuration
  logic [7:0]        seed_q;
  logic [WaterW-1:0] water_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      water_q <= WaterLevelRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgNoiseSeed:  seed_q  <= cfg_data_i[7:0];
        CfgWaterLevel: water_q <= cfg_data_i[WaterW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] stg_en;

  always_comb begin
    stg_en[NumStg-1] = !vld_q[NumStg-1] || rsp.ready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      stg_en[k] = !vld_q[k] || stg_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (stg_en[0]) begin
        vld_q[0] <= req.valid;
      end
      for (int k = 1; k < NumStg; k++) begin
        if (stg_en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign req.ready = stg_en[0];
  assign rsp.valid = vld_q[NumStg-1];

  // stage 1: scale coordinates, split into cell and fraction
  logic signed [28:0] px_d [2];
  logic signed [28:0] pz_d [2];
  logic [7:0]         s1_xc_q [2];
  logic [7:0]         s1_zc_q [2];
  logic [15:0]        s1_xf_q [2];
  logic [15:0]        s1_zf_q [2];
  logic [PosYW-1:0]   s1_y_q;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      px_d[o] = $signed(req.pos_x) * $signed(OctScale[o]);
      pz_d[o] = $signed(req.pos_z) * $signed(OctScale[o]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[0]) begin
      for (int o = 0; o < 2; o++) begin
        s1_xc_q[o] <= px_d[o][23:16];
        s1_xf_q[o] <= px_d[o][15:0];
        s1_zc_q[o] <= pz_d[o][23:16];
        s1_zf_q[o] <= pz_d[o][15:0];
      end
      s1_y_q <= req.pos_y;
    end
  end

  // stage 2: corner hashes, squared fractions
  logic [7:0]       seed_lo [2];
  logic [7:0]       xa_d [2];
  logic [7:0]       xb_d [2];
  logic [7:0]       za_d [2];
  logic [7:0]       zb_d [2];
  logic [31:0]      sqx_d [2];
  logic [31:0]      sqz_d [2];
  logic [7:0]       s2_c_q [2][4];
  logic [15:0]      s2_xf_q [2];
  logic [15:0]      s2_zf_q [2];
  logic [15:0]      s2_xf2_q [2];
  logic [15:0]      s2_zf2_q [2];
  logic [PosYW-1:0] s2_y_q;

  assign seed_lo[0] = seed_q;
  assign seed_lo[1] = seed_q + 8'd1;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      xa_d[o]  = s1_xc_q[o] + seed_lo[o];
      xb_d[o]  = xa_d[o] + 8'd1;
      za_d[o]  = s1_zc_q[o] + seed_lo[o];
      zb_d[o]  = za_d[o] + 8'd1;
      sqx_d[o] = s1_xf_q[o] * s1_xf_q[o];
      sqz_d[o] = s1_zf_q[o] * s1_zf_q[o];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[1]) begin
      for (int o = 0; o < 2; o++) begin
        s2_c_q[o][0] <= corner_hash(xa_d[o], za_d[o]);
        s2_c_q[o][1] <= corner_hash(xb_d[o], za_d[o]);
        s2_c_q[o][2] <= corner_hash(xa_d[o], zb_d[o]);
        s2_c_q[o][3] <= corner_hash(xb_d[o], zb_d[o]);
        s2_xf_q[o]   <= s1_xf_q[o];
        s2_zf_q[o]   <= s1_zf_q[o];
        s2_xf2_q[o]  <= sqx_d[o][31:16];
        s2_zf2_q[o]  <= sqz_d[o][31:16];
      end
      s2_y_q <= s1_y_q;
    end
  end

  // stage 3: smoothstep of both fractions
  logic [17:0]      tx_d [2];
  logic [17:0]      tz_d [2];
  logic [33:0]      ux_d [2];
  logic [33:0]      uz_d [2];
  logic [16:0]      s3_u_q [2];
  logic [16:0]      s3_v_q [2];
  logic [7:0]       s3_c_q [2][4];
  logic [PosYW-1:0] s3_y_q;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      tx_d[o] = SmoothThree - {1'b0, s2_xf_q[o], 1'b0};
      tz_d[o] = SmoothThree - {1'b0, s2_zf_q[o], 1'b0};
      ux_d[o] = 34'(s2_xf2_q[o]) * 34'(tx_d[o]);
      uz_d[o] = 34'(s2_zf2_q[o]) * 34'(tz_d[o]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[2]) begin
      for (int o = 0; o < 2; o++) begin
        s3_u_q[o] <= ux_d[o][32:16];
        s3_v_q[o] <= uz_d[o][32:16];
        for (int c = 0; c < 4; c++) begin
          s3_c_q[o][c] <= s2_c_q[o][c];
        end
      end
      s3_y_q <= s2_y_q;
    end
  end

  // stage 4: interpolate along x
  logic signed [8:0]  da_d [2];
  logic signed [8:0]  db_d [2];
  logic signed [26:0] pa_d [2];
  logic signed [26:0] pb_d [2];
  logic signed [26:0] aw_d [2];
  logic signed [26:0] bw_d [2];
  logic signed [24:0] s4_a_q [2];
  logic signed [24:0] s4_b_q [2];
  logic [16:0]        s4_v_q [2];
  logic [PosYW-1:0]   s4_y_q;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      da_d[o] = $signed({1'b0, s3_c_q[o][1]}) - $signed({1'b0, s3_c_q[o][0]});
      db_d[o] = $signed({1'b0, s3_c_q[o][3]}) - $signed({1'b0, s3_c_q[o][2]});
      pa_d[o] = $signed({1'b0, s3_u_q[o]}) * da_d[o];
      pb_d[o] = $signed({1'b0, s3_u_q[o]}) * db_d[o];
      aw_d[o] = $signed({3'b0, s3_c_q[o][0], 16'h0}) + pa_d[o];
      bw_d[o] = $signed({3'b0, s3_c_q[o][2], 16'h0}) + pb_d[o];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[3]) begin
      for (int o = 0; o < 2; o++) begin
        s4_a_q[o] <= aw_d[o][24:0];
        s4_b_q[o] <= bw_d[o][24:0];
        s4_v_q[o] <= s3_v_q[o];
      end
      s4_y_q <= s3_y_q;
    end
  end

  // stage 5: interpolate along z, floor at zero
  logic signed [25:0] dn_d [2];
  logic signed [43:0] pn_d [2];
  logic signed [43:0] nw_d [2];
  logic [39:0]        s5_n_q [2];
  logic [PosYW-1:0]   s5_y_q;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      dn_d[o] = {s4_b_q[o][24], s4_b_q[o]} - {s4_a_q[o][24], s4_a_q[o]};
      pn_d[o] = $signed({1'b0, s4_v_q[o]}) * dn_d[o];
      nw_d[o] = $signed({{3{s4_a_q[o][24]}}, s4_a_q[o], 16'h0}) + pn_d[o];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[4]) begin
      for (int o = 0; o < 2; o++) begin
        s5_n_q[o] <= nw_d[o][43] ? '0 : nw_d[o][39:0];
      end
      s5_y_q <= s4_y_q;
    end
  end

  // stage 6: weight and sum the octaves, keep the integer part
  logic [45:0]      num_d;
  logic [13:0]      s6_m_q;
  logic [PosYW-1:0] s6_y_q;

  assign num_d = (46'(s5_n_q[0]) << 4) + (46'(s5_n_q[0]) << 2)
               + (46'(s5_n_q[1]) << 5) + (46'(s5_n_q[1]) << 3);

  always_ff @(posedge clk_i) begin
    if (stg_en[5]) begin
      s6_m_q <= num_d[45:32];
      s6_y_q <= s5_y_q;
    end
  end

  // stage 7: divide by 255, offset and clamp the height
  logic [22:0]      mq_d;
  logic [6:0]       q0_d;
  logic [14:0]      qm_d;
  logic [14:0]      rem_d;
  logic [6:0]       q_d;
  logic [7:0]       hraw_d;
  logic [7:0]       hcl_d;
  logic [7:0]       s7_h_q;
  logic [PosYW-1:0] s7_y_q;

  always_comb begin
    mq_d   = 23'({s6_m_q, 8'h0}) + 23'(s6_m_q);
    q0_d   = mq_d[22:16];
    qm_d   = 15'({q0_d, 8'h0}) - 15'(q0_d);
    rem_d  = 15'(s6_m_q) - qm_d;
    q_d    = (rem_d >= ValueSpan) ? q0_d + 7'd1 : q0_d;
    hraw_d = HeightBase + 8'(q_d);
    if (hraw_d > HMax) begin
      hcl_d = HMax;
    end else if (hraw_d == 8'd0) begin
      hcl_d = 8'd1;
    end else begin
      hcl_d = hraw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[6]) begin
      s7_h_q <= hcl_d;
      s7_y_q <= s6_y_q;
    end
  end

  // stage 8: classify the voxel, output register
  logic [8:0]        y9;
  logic [8:0]        h9;
  logic [8:0]        wl9;
  block_kind_e       kind_d;
  logic [KindW-1:0]  s8_kind_q;
  logic [ColHW-1:0]  s8_h_q;

  assign y9  = {2'b0, s7_y_q};
  assign h9  = {1'b0, s7_h_q};
  assign wl9 = {2'b0, water_q};

  always_comb begin
    if (y9 >= HLimit) begin
      kind_d = KindAir;
    end else if (y9 < h9) begin
      if (y9 < BedrockTop) begin
        kind_d = KindBedrock;
      end else if (y9 + DirtDepth < h9) begin
        kind_d = KindStone;
      end else if (y9 + 9'd1 < h9) begin
        kind_d = KindDirt;
      end else if (h9 > wl9) begin
        kind_d = KindGrass;
      end else begin
        kind_d = KindDirt;
      end
    end else if (y9 <= wl9) begin
      kind_d = KindWater;
    end else begin
      kind_d = KindAir;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_en[7]) begin
      s8_kind_q <= kind_d;
      s8_h_q    <= s7_h_q[ColHW-1:0];
    end
  end

  assign rsp.block_kind    = s8_kind_q;
  assign rsp.column_height = s8_h_q;

endmodule

`default_nettype wire

FILE: bench/tb_noise_terrain_block_classifier.sv
`timescale 1ns / 1ps
// Testbench of noise_terrain_block_classifier: streams voxel requests with random idling,
// predicts block kind and column height per request and checks the results in order.
// Depends on ntbc_pkg, ntbc_if and the classifier top level.

module tb_noise_terrain_block_classifier;
  import ntbc_pkg::*;

  localparam int     Height      = HeightDef;
  localparam int     Scale1      = 3277;
  localparam int     Scale2      = 655;
  localparam logic [31:0] HashX  = 32'd73856093;
  localparam logic [31:0] HashY  = 32'd19349663;
  localparam longint NoiseOne    = longint'(255) << 32;
  localparam int     NumDirected = 24;
  localparam int     LongHold    = 200;
  localparam int     HoldAtA     = 300;
  localparam int     HoldAtB     = 700;
  localparam int     Drain       = 20;
  localparam int     Limit       = 100000;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic [PosYW-1:0]         y;
    logic signed [CoordW-1:0] z;
  } voxel_req_t;

  typedef struct {
    voxel_req_t       req;
    block_kind_e      kind;
    logic [ColHW-1:0] height;
  } voxel_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  ntbc_req_if req_if ();
  ntbc_rsp_if rsp_if ();

  noise_terrain_block_classifier i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  voxel_req_t    voxel_q [$];
  voxel_result_t result_q [$];
  voxel_req_t    next_voxel;
  voxel_result_t want;

  int unsigned seed_cfg  = 0;
  int          water_cfg = WaterLevelRst;
  int          n_pushed  = 0;
  int          n_sent    = 0;
  int          n_errors  = 0;
  int          cycle_cnt = 0;
  int          req_gap   = 0;
  int          rsp_gap   = 0;
  int          hold_cnt  = 0;
  int          hold_mark = -1;
  bit          req_fired = 1'b0;
  bit          rsp_fired = 1'b0;
  bit          no_idle   = 1'b0;

  int dir_x [8] = '{0, -32768, 32767, -32768, 32767, -1, 1, -21};
  int dir_z [8] = '{0, -32768, 32767, 32767, -32768, -1, 1, 20};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Q16.16 product: low byte of the floored cell and the fraction
  function automatic void split_coord(input logic signed [CoordW-1:0] coord, input int scale,
                                      output logic [7:0] cell_lo, output logic [15:0] frac);
    logic signed [31:0] prod;
    prod    = coord * scale;
    cell_lo = prod[23:16];
    frac    = prod[15:0];
  endfunction

  function automatic longint corner_value(input int unsigned cx, input int unsigned cy,
                                          input int unsigned seed);
    logic [31:0] hv;
    hv = ((cx + seed) * HashX) ^ ((cy + seed) * HashY);
    return longint'(hv[7:0]);
  endfunction

  function automatic longint fade(input logic [15:0] f);
    longint sq;
    longint ramp;
    sq   = (longint'(f) * longint'(f)) >> 16;
    ramp = 196608 - 2 * longint'(f);
    return (sq * ramp) >> 16;
  endfunction

  function automatic longint noise_octave(input logic signed [CoordW-1:0] x,
                                          input logic signed [CoordW-1:0] z,
                                          input int scale, input int unsigned seed);
    logic [7:0]  xi;
    logic [7:0]  zi;
    logic [15:0] xf;
    logic [15:0] zf;
    longint c00, c10, c01, c11, u, v, a, b, n;
    split_coord(x, scale, xi, xf);
    split_coord(z, scale, zi, zf);
    c00 = corner_value(32'(xi), 32'(zi), seed);
    c10 = corner_value(32'(xi) + 1, 32'(zi), seed);
    c01 = corner_value(32'(xi), 32'(zi) + 1, seed);
    c11 = corner_value(32'(xi) + 1, 32'(zi) + 1, seed);
    u = fade(xf);
    v = fade(zf);
    a = c00 * 65536 + u * (c10 - c00);
    b = c01 * 65536 + u * (c11 - c01);
    n = a * 65536 + v * (b - a);
    return (n < 0) ? 0 : n;
  endfunction

  function automatic int column_height_at(input logic signed [CoordW-1:0] x,
                                          input logic signed [CoordW-1:0] z);
    longint n1, n2, lvl;
    n1  = noise_octave(x, z, Scale1, seed_cfg);
    n2  = noise_octave(x, z, Scale2, seed_cfg + 1);
    lvl = 64 + (20 * n1 + 40 * n2) / NoiseOne;
    if (lvl > Height - 1) lvl = Height - 1;
    if (lvl < 1) lvl = 1;
    return int'(lvl);
  endfunction

  function automatic voxel_result_t classify_voxel(input voxel_req_t vr);
    voxel_result_t r;
    int h;
    int y;
    h = column_height_at(vr.x, vr.z);
    y = int'(vr.y);
    r.req    = vr;
    r.height = ColHW'(h);
    if (y >= Height) r.kind = KindAir;
    else if (y < h) begin
      if (y < 4) r.kind = KindBedrock;
      else if (y < h - 3) r.kind = KindStone;
      else if (y < h - 1) r.kind = KindDirt;
      else r.kind = (h > water_cfg) ? KindGrass : KindDirt;
    end else if (y <= water_cfg) r.kind = KindWater;
    else r.kind = KindAir;
    return r;
  endfunction

  // pick y around the layer boundaries of a column of height h and the water level, or at random
  function automatic int voxel_y_near(input int sel, input int h);
    int y;
    case (sel)
      0:       y = 0;
      1:       y = 3;
      2:       y = 4;
      3:       y = h - 4;
      4:       y = h - 3;
      5:       y = h - 2;
      6:       y = h - 1;
      7:       y = h;
      8:       y = water_cfg;
      9:       y = water_cfg + 1;
      10:      y = 127;
      default: y = $urandom_range(0, 127);
    endcase
    if (y < 0) y = 0;
    if (y > 127) y = 127;
    return y;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < 100) $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  task automatic push_voxel(input int x, input int y, input int z);
    voxel_q.push_back({CoordW'(x), PosYW'(y), CoordW'(z)});
    n_pushed++;
  endtask

  task automatic push_random_voxel();
    int x;
    int z;
    int h;
    case ($urandom_range(0, 3))
      1: begin
        x = int'($urandom_range(0, 800)) - 400;
        z = int'($urandom_range(0, 800)) - 400;
      end
      2: begin
        x = $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 15))
                                 : 32767 - int'($urandom_range(0, 15));
        z = $urandom_range(0, 1) ? -32768 + int'($urandom_range(0, 15))
                                 : 32767 - int'($urandom_range(0, 15));
      end
      default: begin
        x = int'($urandom_range(0, 65535)) - 32768;
        z = int'($urandom_range(0, 65535)) - 32768;
      end
    endcase
    h = column_height_at(CoordW'(x), CoordW'(z));
    push_voxel(x, voxel_y_near($urandom_range(0, 13), h), z);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgNoiseSeed) seed_cfg = data;
    else water_cfg = int'(data[WaterW-1:0]);
  endtask

  task automatic wait_idle();
    while (n_sent != n_pushed || result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) push_random_voxel();
    wait_idle();
  endtask

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_fired) begin
      if (req_gap != 0) begin
        req_if.valid <= 1'b0;
        req_gap      <= req_gap - 1;
      end else if (voxel_q.size() != 0) begin
        next_voxel    = voxel_q.pop_front();
        req_if.valid <= 1'b1;
        req_if.pos_x <= next_voxel.x;
        req_if.pos_y <= next_voxel.y;
        req_if.pos_z <= next_voxel.z;
        req_gap      <= no_idle ? 0 : $urandom_range(0, 3);
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // result ready control
  always @(negedge clk_i) begin
    if (!rst_ni || hold_cnt != 0) begin
      rsp_if.ready <= 1'b0;
    end else if (!rsp_if.ready || rsp_fired) begin
      if (rsp_gap != 0) begin
        rsp_if.ready <= 1'b0;
        rsp_gap      <= rsp_gap - 1;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_gap      <= no_idle ? 0 : $urandom_range(0, 3);
      end
    end
  end

  // hold off results for a long stretch so the pipeline backs up
  always @(negedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if ((n_sent == HoldAtA || n_sent == HoldAtB) && hold_mark != n_sent) begin
      hold_cnt  <= LongHold;
      hold_mark <= n_sent;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_fired <= req_if.valid && req_if.ready;
      rsp_fired <= rsp_if.valid && rsp_if.ready;
      if (req_if.valid && req_if.ready) begin
        result_q.push_back(classify_voxel({req_if.pos_x, req_if.pos_y, req_if.pos_z}));
        n_sent++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (result_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (rsp_if.block_kind !== want.kind)
            report_mismatch($sformatf("block_kind %0d, want %0d (x %0d y %0d z %0d)",
                                      rsp_if.block_kind, want.kind, want.req.x,
                                      want.req.y, want.req.z));
          if (rsp_if.column_height !== want.height)
            report_mismatch($sformatf("column_height %0d, want %0d (x %0d y %0d z %0d)",
                                      rsp_if.column_height, want.height, want.req.x,
                                      want.req.y, want.req.z));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == Limit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int h;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgNoiseSeed;
    cfg_data_i   = '0;
    req_if.valid = 1'b0;
    req_if.pos_x = '0;
    req_if.pos_y = '0;
    req_if.pos_z = '0;
    rsp_if.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // layer boundaries, coordinate extremes and negative floors at reset settings
    for (int i = 0; i < NumDirected; i++) begin
      h = column_height_at(CoordW'(dir_x[i % 8]), CoordW'(dir_z[i % 8]));
      push_voxel(dir_x[i % 8], voxel_y_near(i % 12, h), dir_z[i % 8]);
    end
    run_random(200);

    write_reg(CfgNoiseSeed, 32'hFFFF_FFFF);
    write_reg(CfgWaterLevel, 32'd127);
    run_random(206);

    write_reg(CfgNoiseSeed, $urandom());
    write_reg(CfgWaterLevel, 32'd0);
    run_random(206);

    write_reg(CfgNoiseSeed, $urandom());
    write_reg(CfgWaterLevel, $urandom_range(0, 127));
    run_random(206);

    write_reg(CfgNoiseSeed, 32'd0);
    write_reg(CfgWaterLevel, $urandom_range(50, 80));
    no_idle = 1'b1;
    run_random(206);

    repeat (Drain) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/ntbc_pkg.sv
rtl/core/ntbc_if.sv
rtl/core/noise_terrain_block_classifier.sv
bench/tb_noise_terrain_block_classifier.sv
